>>> hw/rtl/flvp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// flvp_pkg
// Shared types, constants and helper functions of the FLV tag stream parser.
// ----------------------------------------------------------------------------
package flvp_pkg;

	// width of the saturating tag counters
	localparam int COUNT_BITS = 24;

	// result queue
	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

	typedef logic [COUNT_BITS-1:0] count_t;
	typedef logic [FIFO_AW-1:0]    fifo_ptr_t;
	typedef logic [FIFO_AW:0]      fifo_cnt_t;

	typedef enum logic [2:0] {
		PH_FILE    = 3'b001,
		PH_TAG     = 3'b010,
		PH_PAYLOAD = 3'b100
	} phase_t;

	// result kinds
	localparam logic [1:0] KIND_HEADER  = 2'd0;
	localparam logic [1:0] KIND_TAG     = 2'd1;
	localparam logic [1:0] KIND_SUMMARY = 2'd2;

	// tag types
	localparam logic [7:0] TAG_AUDIO  = 8'h08;
	localparam logic [7:0] TAG_VIDEO  = 8'h09;
	localparam logic [7:0] TAG_SCRIPT = 8'h12;

	// byte positions inside the file header
	localparam logic [3:0] IDX_VERSION   = 4'd3;
	localparam logic [3:0] IDX_FLAGS     = 4'd4;
	localparam logic [3:0] IDX_OFFSET    = 4'd5;
	localparam logic [3:0] FILE_HDR_LAST = 4'd8;

	// byte positions inside a previous-size plus tag header unit
	localparam logic [3:0] IDX_TYPE     = 4'd4;
	localparam logic [3:0] IDX_TIME     = 4'd8;
	localparam logic [3:0] IDX_EXT      = 4'd11;
	localparam logic [3:0] TAG_HDR_LAST = 4'd14;

	// header flag bits
	localparam int FLAG_AUDIO_BIT = 2;
	localparam int FLAG_VIDEO_BIT = 0;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       end_of_stream;
	} item_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [7:0]  type_or_version;
		logic [31:0] prev_size_or_offset;
		logic [23:0] payload_size;
		logic [23:0] time_stamp;
		logic [7:0]  time_stamp_ext;
		logic [23:0] stream_ident;
		logic [7:0]  first_payload;
		logic [3:0]  sound_format;
		logic [1:0]  sound_rate;
		logic        sound_wide;
		logic        sound_stereo;
	} result_t;

	// up to two results written into the queue in one cycle, in order
	typedef struct packed {
		logic [1:0] num;
		result_t    first;
		result_t    second;
	} push_t;

	function automatic count_t sat_inc(count_t v);
		return (v != '1) ? v + count_t'(1) : v;
	endfunction

	function automatic logic [23:0] clip24(count_t v);
		logic [32:0] w;
		w = 33'(v);
		return (w > 33'h0FFFFFF) ? 24'hFFFFFF : w[23:0];
	endfunction

	function automatic logic [31:0] total32(count_t v);
		logic [32:0] w;
		w = 33'(v) + 33'd1;
		return w[32] ? 32'hFFFFFFFF : w[31:0];
	endfunction

endpackage

>>> hw/rtl/flvp_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// flvp_core
// Input register and single-pass byte parser: file header, tag headers,
// payload skipping, tag counters and the end-of-stream summary.
// ----------------------------------------------------------------------------
module flvp_core (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             item_valid,
	output logic             item_stall,
	input  flvp_pkg::item_t  item,
	input  logic             space,
	output flvp_pkg::push_t  push
);
	import flvp_pkg::*;

	logic        valid_s1;
	item_t       item_s1;
	logic        fire;

	phase_t      phase_q, phase_d;
	logic [3:0]  idx_q, idx_d;
	logic [31:0] shift_q, shift_d;
	logic [7:0]  type_q, type_d;
	logic [23:0] size_q, size_d;
	logic [23:0] time_q, time_d;
	logic [7:0]  ext_q, ext_d;
	logic [23:0] stream_q, stream_d;
	logic [23:0] left_q, left_d;
	logic [7:0]  first_q, first_d;
	logic [7:0]  version_q, version_d;
	logic [7:0]  flags_q, flags_d;
	count_t      video_q, video_d;
	count_t      audio_q, audio_d;
	count_t      script_q, script_d;
	count_t      complete_q, complete_d;

	logic        hdr_done;
	logic        tag_done;
	logic [7:0]  b;
	result_t     res_a;
	result_t     res_sum;

	assign fire       = valid_s1 && space;
	assign item_stall = valid_s1 && !space;
	assign b          = item_s1.data_byte;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!item_stall) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && !item_stall) begin
			item_s1 <= item;
		end
	end

	always_comb begin
		phase_d    = phase_q;
		idx_d      = idx_q;
		shift_d    = shift_q;
		type_d     = type_q;
		size_d     = size_q;
		time_d     = time_q;
		ext_d      = ext_q;
		stream_d   = stream_q;
		left_d     = left_q;
		first_d    = first_q;
		version_d  = version_q;
		flags_d    = flags_q;
		video_d    = video_q;
		audio_d    = audio_q;
		script_d   = script_q;
		complete_d = complete_q;
		hdr_done   = 1'b0;
		tag_done   = 1'b0;
		res_a      = '0;
		res_sum    = '0;
		push       = '0;

		if (fire) begin
			case (phase_q)
				PH_FILE: begin
					if (idx_q == IDX_VERSION) begin
						version_d = b;
					end else if (idx_q == IDX_FLAGS) begin
						flags_d = b;
					end else if (idx_q >= IDX_OFFSET) begin
						shift_d = {shift_q[23:0], b};
					end
					idx_d = idx_q + 4'd1;
					if (idx_q == FILE_HDR_LAST) begin
						hdr_done                  = 1'b1;
						res_a.kind                = KIND_HEADER;
						res_a.type_or_version     = version_q;
						res_a.prev_size_or_offset = {shift_q[23:0], b};
						res_a.sound_wide          = flags_q[FLAG_AUDIO_BIT];
						res_a.sound_stereo        = flags_q[FLAG_VIDEO_BIT];
						phase_d                   = PH_TAG;
						idx_d                     = '0;
						shift_d                   = '0;
					end
				end
				PH_TAG: begin
					if (idx_q < IDX_TYPE) begin
						shift_d = {shift_q[23:0], b};
					end else if (idx_q == IDX_TYPE) begin
						type_d = b;
					end else if (idx_q < IDX_TIME) begin
						size_d = {size_q[15:0], b};
					end else if (idx_q < IDX_EXT) begin
						time_d = {time_q[15:0], b};
					end else if (idx_q == IDX_EXT) begin
						ext_d = b;
					end else begin
						stream_d = {stream_q[15:0], b};
					end
					idx_d = idx_q + 4'd1;
					if (idx_q == TAG_HDR_LAST) begin
						idx_d = '0;
						// type counts rise at header completion, payload or not
						if (type_q == TAG_AUDIO) begin
							audio_d = sat_inc(audio_q);
						end else if (type_q == TAG_VIDEO) begin
							video_d = sat_inc(video_q);
						end else if (type_q == TAG_SCRIPT) begin
							script_d = sat_inc(script_q);
						end
						if (size_q == '0) begin
							first_d  = '0;
							tag_done = 1'b1;
						end else begin
							left_d  = size_q;
							phase_d = PH_PAYLOAD;
						end
					end
				end
				PH_PAYLOAD: begin
					if (left_q == size_q) begin
						first_d = b;
					end
					if (left_q != '0) begin
						left_d = left_q - 24'd1;
					end
					if (left_d == '0) begin
						tag_done = 1'b1;
						phase_d  = PH_TAG;
					end
				end
				default: begin
					phase_d = PH_FILE;
				end
			endcase

			if (tag_done) begin
				res_a.kind                = KIND_TAG;
				res_a.type_or_version     = type_d;
				res_a.prev_size_or_offset = shift_d;
				res_a.payload_size        = size_d;
				res_a.time_stamp          = time_d;
				res_a.time_stamp_ext      = ext_d;
				res_a.stream_ident        = stream_d;
				if (type_d == TAG_AUDIO || type_d == TAG_VIDEO) begin
					res_a.first_payload = first_d;
				end
				if (type_d == TAG_AUDIO) begin
					res_a.sound_format = first_d[7:4];
					res_a.sound_rate   = first_d[3:2];
					res_a.sound_wide   = first_d[1];
					res_a.sound_stereo = first_d[0];
				end
				complete_d = sat_inc(complete_q);
			end

			res_sum.kind                = KIND_SUMMARY;
			res_sum.prev_size_or_offset = total32(complete_d);
			res_sum.payload_size        = clip24(video_d);
			res_sum.time_stamp          = clip24(audio_d);
			res_sum.stream_ident        = clip24(script_d);

			// at end of stream the summary goes after a header or tag from the same byte
			if (hdr_done || tag_done) begin
				push.first  = res_a;
				push.second = res_sum;
				push.num    = item_s1.end_of_stream ? 2'd2 : 2'd1;
			end else begin
				push.first  = res_sum;
				push.num    = item_s1.end_of_stream ? 2'd1 : 2'd0;
			end

			if (item_s1.end_of_stream) begin
				phase_d    = PH_FILE;
				idx_d      = '0;
				shift_d    = '0;
				type_d     = '0;
				size_d     = '0;
				time_d     = '0;
				ext_d      = '0;
				stream_d   = '0;
				left_d     = '0;
				first_d    = '0;
				version_d  = '0;
				flags_d    = '0;
				video_d    = '0;
				audio_d    = '0;
				script_d   = '0;
				complete_d = '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_FILE;
			idx_q      <= '0;
			shift_q    <= '0;
			type_q     <= '0;
			size_q     <= '0;
			time_q     <= '0;
			ext_q      <= '0;
			stream_q   <= '0;
			left_q     <= '0;
			first_q    <= '0;
			version_q  <= '0;
			flags_q    <= '0;
			video_q    <= '0;
			audio_q    <= '0;
			script_q   <= '0;
			complete_q <= '0;
		end else begin
			phase_q    <= phase_d;
			idx_q      <= idx_d;
			shift_q    <= shift_d;
			type_q     <= type_d;
			size_q     <= size_d;
			time_q     <= time_d;
			ext_q      <= ext_d;
			stream_q   <= stream_d;
			left_q     <= left_d;
			first_q    <= first_d;
			version_q  <= version_d;
			flags_q    <= flags_d;
			video_q    <= video_d;
			audio_q    <= audio_d;
			script_q   <= script_d;
			complete_q <= complete_d;
		end
	end

	a_eos_restart: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && item_s1.end_of_stream) |=> (phase_q == PH_FILE && idx_q == '0))
		else $error("parser did not restart after end of stream");

	a_payload_left: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_PAYLOAD) |-> (left_q != '0))
		else $error("payload phase with nothing left to skip");

	a_file_idx: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_FILE) |-> (idx_q <= FILE_HDR_LAST))
		else $error("file header byte index out of range");

	a_tag_idx: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_TAG) |-> (idx_q <= TAG_HDR_LAST))
		else $error("tag header byte index out of range");

	a_stall_held: assert property (@(posedge clk) disable iff (!arst_n)
		item_stall |-> valid_s1)
		else $error("input stalled with empty input register");

endmodule

>>> hw/rtl/flvp_out_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// flvp_out_fifo
// Result queue: takes up to two results per cycle, hands out one per
// transaction on the result channel.
// ----------------------------------------------------------------------------
module flvp_out_fifo (
	input  logic              clk,
	input  logic              arst_n,
	input  flvp_pkg::push_t   push,
	output logic              space,
	output logic              result_valid,
	input  logic              result_stall,
	output flvp_pkg::result_t result
);
	import flvp_pkg::*;

	result_t   mem [FIFO_DEPTH];
	fifo_ptr_t wr_q;
	fifo_ptr_t rd_q;
	fifo_cnt_t count_q;
	logic      pop;

	assign result_valid = (count_q != '0);
	assign result       = mem[rd_q];
	assign pop          = result_valid && !result_stall;
	// room for a result pair regardless of the output side
	assign space        = (count_q <= fifo_cnt_t'(FIFO_DEPTH - 2));

	always_ff @(posedge clk) begin
		if (push.num != 2'd0) begin
			mem[wr_q] <= push.first;
		end
		if (push.num == 2'd2) begin
			mem[wr_q + fifo_ptr_t'(1)] <= push.second;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			wr_q    <= wr_q + fifo_ptr_t'(push.num);
			rd_q    <= rd_q + fifo_ptr_t'(pop);
			count_q <= count_q + fifo_cnt_t'(push.num) - fifo_cnt_t'(pop);
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		(push.num != 2'd0) |-> (count_q + fifo_cnt_t'(push.num) <= fifo_cnt_t'(FIFO_DEPTH)))
		else $error("result queue overflow");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= fifo_cnt_t'(FIFO_DEPTH))
		else $error("result queue count out of range");

	a_pop_only: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && push.num == 2'd0) |=> (count_q == $past(count_q) - fifo_cnt_t'(1)))
		else $error("result queue count did not drop on read");

endmodule

>>> hw/rtl/flv_tag_stream_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// flv_tag_stream_parser
// FLV container parser: file header, tag headers, tag counts and summary.
// ----------------------------------------------------------------------------
// Usage:
//   item channel (item_valid / item_stall / item) carries one stream byte per
//   transaction; end_of_stream marks the final byte of a stream.
//   result channel (result_valid / result_stall / result) carries the file
//   header report, one report per complete tag, and a summary after the
//   final byte. A byte gives zero, one or two results.
//   Path: an accepted byte is held in the input register and parsed from
//   there; its results are written into the result queue, which drives the
//   result channel.
//   Throughput: one byte per cycle. The parser works on a byte only while the
//   four-entry result queue holds two results or fewer, so item_stall rises
//   only when the receiver leaves results waiting in the queue.
//   A stalled receiver never loses results; the parser stops and holds its
//   input register until space frees up.
//   Reset: arst_n clears the parser to the start of a file header and empties
//   the queue. After an end-of-stream byte the parser restarts the same way.
// ----------------------------------------------------------------------------
module flv_tag_stream_parser (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_stall,
	input  flvp_pkg::item_t   item,
	output logic              result_valid,
	input  logic              result_stall,
	output flvp_pkg::result_t result
);
	import flvp_pkg::*;

	push_t push;
	logic  space;

	flvp_core u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.item       (item),
		.space      (space),
		.push       (push)
	);

	flvp_out_fifo u_fifo (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.space        (space),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

endmodule

>>> test/flv_parse_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// flv_parse_checker
// Watches both channels of the FLV tag stream parser. It follows every
// accepted stream byte through its own parse of the file header, the tag
// headers and the payload lengths, queues the reports that byte must
// produce, and compares each result transaction against the oldest one.
// ----------------------------------------------------------------------------
module flv_parse_checker (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	input  logic              item_stall,
	input  flvp_pkg::item_t   item,
	input  logic              result_valid,
	input  logic              result_stall,
	input  flvp_pkg::result_t result,
	output int                mismatch_count,
	output int                reports_due
);
	import flvp_pkg::*;

	result_t pending_reports[$];
	result_t want;
	int      errors;

	// parser state
	phase_t      ph;
	logic [3:0]  idx;
	logic [31:0] shift;
	logic [7:0]  ver;
	logic [7:0]  flags;
	logic [7:0]  cur_type;
	logic [7:0]  cur_ext;
	logic [7:0]  first_byte;
	logic [23:0] cur_size;
	logic [23:0] cur_time;
	logic [23:0] cur_stream;
	logic [23:0] left;
	count_t      video_cnt;
	count_t      audio_cnt;
	count_t      script_cnt;
	count_t      done_cnt;

	task automatic restart_parse();
		ph         = PH_FILE;
		idx        = '0;
		shift      = '0;
		ver        = '0;
		flags      = '0;
		cur_type   = '0;
		cur_ext    = '0;
		first_byte = '0;
		cur_size   = '0;
		cur_time   = '0;
		cur_stream = '0;
		left       = '0;
		video_cnt  = '0;
		audio_cnt  = '0;
		script_cnt = '0;
		done_cnt   = '0;
	endtask

	task automatic report_tag();
		result_t r;
		r                     = '0;
		r.kind                = KIND_TAG;
		r.type_or_version     = cur_type;
		r.prev_size_or_offset = shift;
		r.payload_size        = cur_size;
		r.time_stamp          = cur_time;
		r.time_stamp_ext      = cur_ext;
		r.stream_ident        = cur_stream;
		if (cur_type == TAG_AUDIO || cur_type == TAG_VIDEO)
			r.first_payload = first_byte;
		if (cur_type == TAG_AUDIO) begin
			r.sound_format = first_byte[7:4];
			r.sound_rate   = first_byte[3:2];
			r.sound_wide   = first_byte[1];
			r.sound_stereo = first_byte[0];
		end
		pending_reports.push_back(r);
		if (done_cnt != '1)
			done_cnt++;
	endtask

	task automatic parse_byte(input item_t it);
		logic [7:0]  b;
		logic [32:0] tot;
		result_t     r;
		b = it.data_byte;
		case (ph)
			PH_FILE: begin
				if (idx == IDX_VERSION)
					ver = b;
				else if (idx == IDX_FLAGS)
					flags = b;
				else if (idx >= IDX_OFFSET)
					shift = {shift[23:0], b};
				if (idx == FILE_HDR_LAST) begin
					r                     = '0;
					r.kind                = KIND_HEADER;
					r.type_or_version     = ver;
					r.prev_size_or_offset = shift;
					r.sound_wide          = flags[FLAG_AUDIO_BIT];
					r.sound_stereo        = flags[FLAG_VIDEO_BIT];
					pending_reports.push_back(r);
					ph    = PH_TAG;
					idx   = '0;
					shift = '0;
				end else begin
					idx++;
				end
			end
			PH_TAG: begin
				if (idx < IDX_TYPE)
					shift = {shift[23:0], b};
				else if (idx == IDX_TYPE)
					cur_type = b;
				else if (idx < IDX_TIME)
					cur_size = {cur_size[15:0], b};
				else if (idx < IDX_EXT)
					cur_time = {cur_time[15:0], b};
				else if (idx == IDX_EXT)
					cur_ext = b;
				else
					cur_stream = {cur_stream[15:0], b};
				if (idx == TAG_HDR_LAST) begin
					idx = '0;
					// type counts rise with the header, payload or not
					if (cur_type == TAG_AUDIO) begin
						if (audio_cnt != '1)
							audio_cnt++;
					end else if (cur_type == TAG_VIDEO) begin
						if (video_cnt != '1)
							video_cnt++;
					end else if (cur_type == TAG_SCRIPT) begin
						if (script_cnt != '1)
							script_cnt++;
					end
					if (cur_size == '0) begin
						first_byte = '0;
						report_tag();
					end else begin
						left = cur_size;
						ph   = PH_PAYLOAD;
					end
				end else begin
					idx++;
				end
			end
			default: begin
				if (left == cur_size)
					first_byte = b;
				if (left != '0)
					left--;
				if (left == '0) begin
					report_tag();
					ph = PH_TAG;
				end
			end
		endcase

		if (it.end_of_stream) begin
			r                     = '0;
			r.kind                = KIND_SUMMARY;
			tot                   = 33'(done_cnt) + 33'd1;
			r.prev_size_or_offset = tot[32] ? 32'hFFFF_FFFF : tot[31:0];
			r.payload_size        = (64'(video_cnt) > 64'hFF_FFFF) ? '1 : 24'(video_cnt);
			r.time_stamp          = (64'(audio_cnt) > 64'hFF_FFFF) ? '1 : 24'(audio_cnt);
			r.stream_ident        = (64'(script_cnt) > 64'hFF_FFFF) ? '1 : 24'(script_cnt);
			pending_reports.push_back(r);
			restart_parse();
		end
	endtask

	function automatic string report_str(input result_t r);
		return {$sformatf("kind %0d type %02h prev %08h size %06h ts %06h ext %02h ",
			r.kind, r.type_or_version, r.prev_size_or_offset, r.payload_size,
			r.time_stamp, r.time_stamp_ext),
			$sformatf("sid %06h fb %02h fmt %0d rate %0d wide %0d st %0d",
			r.stream_ident, r.first_payload, r.sound_format, r.sound_rate,
			r.sound_wide, r.sound_stereo)};
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			restart_parse();
			pending_reports.delete();
			errors = 0;
			mismatch_count <= 0;
			reports_due    <= 0;
		end else begin
			// results first: they belong to bytes taken at earlier edges
			if (result_valid === 1'b1 && result_stall === 1'b0) begin
				if (pending_reports.size() == 0) begin
					errors++;
					if (errors <= 10)
						$display("%0t: result with nothing expected: %s", $realtime,
							report_str(result));
				end else begin
					want = pending_reports.pop_front();
					if (result !== want) begin
						errors++;
						if (errors <= 10) begin
							$display("%0t: result mismatch", $realtime);
							$display("  expected %s", report_str(want));
							$display("  actual   %s", report_str(result));
						end
					end
				end
			end
			if (item_valid === 1'b1 && item_stall === 1'b0)
				parse_byte(item);
			mismatch_count <= errors;
			reports_due    <= pending_reports.size();
		end
	end

endmodule

>>> test/flv_tag_stream_parser_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// flv_tag_stream_parser_tb
// Feeds the parser a short directed stream followed by random FLV streams:
// mostly well-formed files with random header and tag contents, plus cut-off
// streams and byte noise. Both channels idle at random; the receiver also
// holds off for a long stretch so the result queue fills and the input stalls.
// ----------------------------------------------------------------------------
module flv_tag_stream_parser_tb;
	import flvp_pkg::*;

	localparam int IDLE_PCT     = 37;
	localparam int RANDOM_BYTES = 900;
	localparam int NOISE_PCT    = 10;
	localparam int CUT_PCT      = 25;

	// sender runs flat out here, covering the receiver hold-off
	localparam int SEND_CALM_FROM = 350;
	localparam int SEND_CALM_TO   = 650;
	localparam int HOLD_FROM      = 400;
	localparam int HOLD_TO        = 560;
	localparam int RECV_CALM_FROM = 1000;
	localparam int RECV_CALM_TO   = 1300;

	// one-byte stream, then a header and an empty audio tag ending the stream
	localparam logic [24*8-1:0] SHORT_FLV = {
		8'h46, 8'h4C, 8'h56, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
		8'h00, 8'h00, 8'h00, 8'h00, 8'h08, 8'h00, 8'h00, 8'h00,
		8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00
	};

	logic    clk = 1'b0;
	logic    arst_n;
	logic    item_valid;
	logic    item_stall;
	item_t   item;
	logic    result_valid;
	logic    result_stall;
	result_t result;
	int      mismatch_count;
	int      reports_due;

	item_t   stream_bytes[$];

	always #5 clk = ~clk;

	flv_tag_stream_parser DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

	flv_parse_checker chk (
		.clk            (clk),
		.arst_n         (arst_n),
		.item_valid     (item_valid),
		.item_stall     (item_stall),
		.item           (item),
		.result_valid   (result_valid),
		.result_stall   (result_stall),
		.result         (result),
		.mismatch_count (mismatch_count),
		.reports_due    (reports_due)
	);

	task automatic put_byte(input logic [7:0] b, input logic eos);
		item_t it;
		it.data_byte     = b;
		it.end_of_stream = eos;
		stream_bytes.push_back(it);
	endtask

	task automatic add_stream();
		logic [7:0]  s[$];
		logic [23:0] sz;
		logic [7:0]  ty;
		int unsigned pick;
		int unsigned tags;
		int unsigned plen;
		int unsigned cut;
		pick = $urandom_range(0, 99);
		if (pick < NOISE_PCT) begin
			plen = $urandom_range(1, 30);
			repeat (plen) s.push_back(8'($urandom));
		end else begin
			if ($urandom_range(0, 1)) begin
				s.push_back(8'h46);
				s.push_back(8'h4C);
				s.push_back(8'h56);
			end else begin
				repeat (3) s.push_back(8'($urandom));
			end
			s.push_back($urandom_range(0, 1) ? 8'h01 : 8'($urandom));
			s.push_back(8'($urandom));
			if ($urandom_range(0, 1)) begin
				s.push_back(8'h00);
				s.push_back(8'h00);
				s.push_back(8'h00);
				s.push_back(8'h09);
			end else begin
				repeat (4) s.push_back(8'($urandom));
			end
			tags = $urandom_range(0, 7);
			for (int t = 0; t < tags; t++) begin
				case ($urandom_range(0, 9))
					0, 1, 2: ty = TAG_AUDIO;
					3, 4, 5: ty = TAG_VIDEO;
					6:       ty = TAG_SCRIPT;
					default: ty = 8'($urandom);
				endcase
				// a cut-off stream may end inside a huge payload
				if (pick < CUT_PCT && t == tags - 1) begin
					sz   = 24'($urandom);
					plen = $urandom_range(0, 4);
				end else begin
					case ($urandom_range(0, 9))
						0, 1:    sz = '0;
						2:       sz = 24'($urandom_range(9, 40));
						default: sz = 24'($urandom_range(1, 8));
					endcase
					plen = sz;
				end
				repeat (4) s.push_back(8'($urandom));
				s.push_back(ty);
				s.push_back(sz[23:16]);
				s.push_back(sz[15:8]);
				s.push_back(sz[7:0]);
				repeat (7) s.push_back(8'($urandom));
				repeat (plen) s.push_back(8'($urandom));
			end
			// trailing previous-tag size of a complete file
			if (pick >= CUT_PCT && $urandom_range(0, 1))
				repeat (4) s.push_back(8'($urandom));
		end
		if (pick >= NOISE_PCT && pick < CUT_PCT)
			cut = $urandom_range(0, s.size() - 1);
		else
			cut = s.size() - 1;
		for (int i = 0; i <= cut; i++)
			put_byte(s[i], i == cut);
	endtask

	// result side: random stalls, one long hold-off, one stretch with none
	initial begin
		int unsigned n;
		bit          hold;
		result_stall = 1'b0;
		n = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			n++;
			if (n >= HOLD_FROM && n < HOLD_TO)
				hold = 1'b1;
			else if (n >= RECV_CALM_FROM && n < RECV_CALM_TO)
				hold = 1'b0;
			else
				hold = ($urandom_range(0, 99) < IDLE_PCT);
			result_stall <= hold;
		end
	end

	initial begin
		int          sent;
		int unsigned k;
		bit          idle;
		arst_n     = 1'b0;
		item_valid = 1'b0;
		item       = '0;
		sent       = 0;
		k          = 0;

		for (int i = 0; i < 24; i++) begin
			if (i == 0)
				put_byte(8'h00, 1'b1);
			put_byte(SHORT_FLV[(23 - i) * 8 +: 8], i == 23);
		end
		while (stream_bytes.size() < RANDOM_BYTES + 25)
			add_stream();

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		while (sent < stream_bytes.size()) begin
			@(posedge clk);
			k++;
			if (item_valid && !item_stall)
				sent++;
			// a stalled transaction keeps its payload
			if (!item_valid || !item_stall) begin
				idle = (k < SEND_CALM_FROM || k >= SEND_CALM_TO) &&
					($urandom_range(0, 99) < IDLE_PCT);
				if (sent < stream_bytes.size() && !idle) begin
					item_valid <= 1'b1;
					item       <= stream_bytes[sent];
				end else begin
					item_valid <= 1'b0;
				end
			end
		end

		k = 0;
		do begin
			@(posedge clk);
			k++;
		end while (reports_due != 0 && k < 5000);
		repeat (20) @(posedge clk);

		if (mismatch_count == 0 && reports_due == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

	initial begin
		#2_000_000;
		$display("Simulation FAILED");
		$finish;
	end

endmodule

>>> sim.f
hw/rtl/flvp_pkg.sv
hw/rtl/flvp_core.sv
hw/rtl/flvp_out_fifo.sv
hw/rtl/flv_tag_stream_parser.sv
test/flv_parse_checker.sv
test/flv_tag_stream_parser_tb.sv
